FILE: src/rshc_pkg.sv
// ----------------------------------------------------------------------------
// rshc_pkg: shared definitions for the RSSI smoother and heat mapper
// Holds the field widths, the serial digit size, the register map and the
// handshake structs between the controller and its serial units.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rshc_pkg;

    // Field widths.
    localparam int DbmW   = 8;
    localparam int LevelW = 16;
    localparam int HeatW  = 8;

    // Serial datapath: the level update moves one digit per cycle.
    localparam int DigitW    = 4;
    localparam int SubW      = 20;
    localparam int SubDigits = SubW / DigitW;
    localparam int AddDigits = LevelW / DigitW;
    localparam int EmaShift  = 2;
    localparam int DigitCntW = 3;

    // Divider: one quotient bit per cycle.
    localparam int DivCntW = 3;

    // Configuration register map.
    localparam int CfgIdxW = 1;
    localparam logic [CfgIdxW-1:0] REG_COLD = 1'b0;
    localparam logic [CfgIdxW-1:0] REG_HOT  = 1'b1;

    localparam logic signed [DbmW-1:0] COLD_RESET = -8'sd90;
    localparam logic signed [DbmW-1:0] HOT_RESET  = -8'sd30;

    localparam logic [HeatW-1:0] HEAT_MAX = 8'd255;

    // Control into a serial unit and status coming back out.
    typedef struct packed {
        logic start;
        logic ack;
    } t_unit_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_stat;

endpackage

FILE: src/rshc_ema.sv
// ----------------------------------------------------------------------------
// rshc_ema: digit-serial exponential moving average
// Keeps the Q8.8 smoothed level. A primed level is updated as
// old + ((sample*256 - old) >>> 2) in two serial passes of 4-bit digits:
// a subtract pass over a 20-bit word, then an add pass over 16 bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rshc_ema
    import rshc_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_unit_ctl                i_ctl,
    input  logic signed [DbmW-1:0]   i_sample,
    output t_unit_stat               o_stat,
    output logic signed [LevelW-1:0] o_level
);

    typedef enum logic [1:0] {
        E_IDLE,
        E_SUB,
        E_ADD
    } t_ema_state;

    t_ema_state             r_state;
    logic [SubW-1:0]        r_a;
    logic [SubW-1:0]        r_b;
    logic [SubW-1:0]        r_acc;
    logic                   r_carry;
    logic [DigitCntW-1:0]   r_cnt;
    logic signed [LevelW-1:0] r_level;
    logic                   r_primed;
    logic                   r_done;

    logic [LevelW-1:0]      target_q8;
    logic [DigitW-1:0]      b_digit;
    logic [DigitW:0]        digit_sum;
    logic [SubW-1:0]        n_acc;

    assign target_q8 = {i_sample, {(LevelW-DbmW){1'b0}}};

    // One digit of the serial adder; the subtract pass inverts the old level.
    always_comb begin
        b_digit   = (r_state == E_SUB) ? ~r_b[DigitW-1:0] : r_b[DigitW-1:0];
        digit_sum = {1'b0, r_a[DigitW-1:0]} + {1'b0, b_digit} + {{DigitW{1'b0}}, r_carry};
        n_acc     = {digit_sum[DigitW-1:0], r_acc[SubW-1:DigitW]};
    end

    // Sequencer for the two serial passes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= E_IDLE;
            r_level  <= '0;
            r_primed <= 1'b0;
            r_done   <= 1'b0;
            r_cnt    <= '0;
            r_carry  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                E_IDLE: begin
                    if (i_ctl.start) begin
                        if (!r_primed) begin
                            r_level  <= target_q8;
                            r_primed <= 1'b1;
                            r_done   <= 1'b1;
                        end else begin
                            r_a     <= {{(SubW-LevelW){target_q8[LevelW-1]}}, target_q8};
                            r_b     <= {{(SubW-LevelW){r_level[LevelW-1]}}, r_level};
                            r_carry <= 1'b1;
                            r_cnt   <= '0;
                            r_state <= E_SUB;
                        end
                    end
                end
                E_SUB: begin
                    r_a     <= r_a >> DigitW;
                    r_b     <= r_b >> DigitW;
                    r_acc   <= n_acc;
                    r_carry <= digit_sum[DigitW];
                    r_cnt   <= r_cnt + DigitCntW'(1);
                    if (r_cnt == DigitCntW'(SubDigits-1)) begin
                        // The difference is complete; add a quarter of it to the level.
                        r_a     <= {{(SubW-LevelW){1'b0}}, r_level};
                        r_b     <= {{(SubW-LevelW){1'b0}}, n_acc[LevelW+EmaShift-1:EmaShift]};
                        r_carry <= 1'b0;
                        r_cnt   <= '0;
                        r_state <= E_ADD;
                    end
                end
                E_ADD: begin
                    r_a     <= r_a >> DigitW;
                    r_b     <= r_b >> DigitW;
                    r_acc   <= n_acc;
                    r_carry <= digit_sum[DigitW];
                    r_cnt   <= r_cnt + DigitCntW'(1);
                    if (r_cnt == DigitCntW'(AddDigits-1)) begin
                        r_level <= n_acc[SubW-1:SubW-LevelW];
                        r_done  <= 1'b1;
                        r_state <= E_IDLE;
                    end
                end
                default: r_state <= E_IDLE;
            endcase
        end
    end

    assign o_stat.busy = (r_state != E_IDLE);
    assign o_stat.done = r_done;
    assign o_level     = r_level;

endmodule

FILE: src/rshc_heat.sv
// ----------------------------------------------------------------------------
// rshc_heat: threshold mapping with a bit-serial divider
// Clamps against the cold and hot thresholds, and otherwise forms
// (dbm - cold) * 255 / (hot - cold) with a restoring divider that
// produces one quotient bit per cycle. The result holds until acknowledged.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rshc_heat
    import rshc_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_unit_ctl              i_ctl,
    input  logic signed [DbmW-1:0] i_dbm,
    input  logic signed [DbmW-1:0] i_cold,
    input  logic signed [DbmW-1:0] i_hot,
    output t_unit_stat             o_stat,
    output logic [HeatW-1:0]       o_heat
);

    typedef enum logic [1:0] {
        H_IDLE,
        H_DIV,
        H_DONE
    } t_heat_state;

    t_heat_state          r_state;
    logic [HeatW-1:0]     r_rem;
    logic [HeatW-1:0]     r_quo;
    logic [HeatW-1:0]     r_den;
    logic [DivCntW-1:0]   r_cnt;

    logic [HeatW-1:0]     span_num;
    logic [HeatW-1:0]     span_den;
    logic [2*HeatW-1:0]   numer;
    logic [HeatW:0]       trial;

    // Numerator (dbm - cold) * 255 as a shift and subtract.
    always_comb begin
        span_num = HeatW'(i_dbm - i_cold);
        span_den = HeatW'(i_hot - i_cold);
        numer    = {span_num, {HeatW{1'b0}}} - {{HeatW{1'b0}}, span_num};
        trial    = {r_rem, r_quo[HeatW-1]} - {1'b0, r_den};
    end

    // Clamp decisions and the divide iterations.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= H_IDLE;
            r_cnt   <= '0;
        end else begin
            unique case (r_state)
                H_IDLE: begin
                    if (i_ctl.start) begin
                        if (i_dbm <= i_cold) begin
                            r_quo   <= '0;
                            r_state <= H_DONE;
                        end else if (i_dbm >= i_hot) begin
                            r_quo   <= HEAT_MAX;
                            r_state <= H_DONE;
                        end else begin
                            // The quotient fits 8 bits, so the upper byte is a valid remainder.
                            r_rem   <= numer[2*HeatW-1:HeatW];
                            r_quo   <= numer[HeatW-1:0];
                            r_den   <= span_den;
                            r_cnt   <= '0;
                            r_state <= H_DIV;
                        end
                    end
                end
                H_DIV: begin
                    if (!trial[HeatW]) begin
                        r_rem <= trial[HeatW-1:0];
                    end else begin
                        r_rem <= {r_rem[HeatW-2:0], r_quo[HeatW-1]};
                    end
                    r_quo <= {r_quo[HeatW-2:0], ~trial[HeatW]};
                    r_cnt <= r_cnt + DivCntW'(1);
                    if (r_cnt == DivCntW'(HeatW-1)) begin
                        r_state <= H_DONE;
                    end
                end
                H_DONE: begin
                    if (i_ctl.ack) begin
                        r_state <= H_IDLE;
                    end
                end
                default: r_state <= H_IDLE;
            endcase
        end
    end

    assign o_stat.busy = (r_state != H_IDLE);
    assign o_stat.done = (r_state == H_DONE);
    assign o_heat      = r_quo;

endmodule

FILE: src/rssi_smoother_heat_colour_top.sv
// A primed level update passes through the 4-bit digit-serial adder, and a
// heat value between the thresholds then goes through the bit-serial divider.
// One sample is in work at a time; the next is taken the cycle after the
// result is loaded, while that result may still wait in the output register.
// Reset (synchronous, active low) clears level and primed flag, thresholds -90/-30 dBm.
// ----------------------------------------------------------------------------
// rssi_smoother_heat_colour_top: RSSI smoother with heat colour output
// Controller, configuration registers and output register around the serial
// moving-average unit and the serial heat divider.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rssi_smoother_heat_colour_top
    import rshc_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic signed [DbmW-1:0] i_rssi_sample,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic signed [DbmW-1:0] o_smoothed_dbm,
    output logic [HeatW-1:0]       o_heat_red,
    output logic [HeatW-1:0]       o_heat_blue,
    input  logic                   i_cfg_we,
    input  logic [CfgIdxW-1:0]     i_cfg_idx,
    input  logic [DbmW-1:0]        i_cfg_data
);

    typedef enum logic [1:0] {
        T_IDLE,
        T_EMA,
        T_HEAT
    } t_top_state;

    t_top_state               r_state;
    logic signed [DbmW-1:0]   r_cold;
    logic signed [DbmW-1:0]   r_hot;
    logic signed [DbmW-1:0]   r_dbm;
    logic                     r_out_valid;
    logic signed [DbmW-1:0]   r_out_dbm;
    logic [HeatW-1:0]         r_out_heat;

    t_unit_ctl                ema_ctl;
    t_unit_stat               ema_stat;
    t_unit_ctl                heat_ctl;
    t_unit_stat               heat_stat;
    logic signed [LevelW-1:0] level;
    logic [HeatW-1:0]         heat;
    logic signed [DbmW-1:0]   level_dbm;
    logic                     out_free;

    // Q8.8 to whole dBm, truncated toward zero.
    always_comb begin
        if (level[LevelW-1] && (level[LevelW-DbmW-1:0] != '0)) begin
            level_dbm = level[LevelW-1:LevelW-DbmW] + DbmW'(1);
        end else begin
            level_dbm = level[LevelW-1:LevelW-DbmW];
        end
    end

    assign out_free      = !r_out_valid || i_out_ready;
    assign o_in_ready    = (r_state == T_IDLE);
    assign ema_ctl.start = (r_state == T_IDLE) && i_in_valid;
    assign ema_ctl.ack   = 1'b0;
    assign heat_ctl.start = (r_state == T_EMA) && ema_stat.done;
    assign heat_ctl.ack   = (r_state == T_HEAT) && heat_stat.done && out_free;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cold <= COLD_RESET;
            r_hot  <= HOT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_COLD: r_cold <= i_cfg_data;
                REG_HOT:  r_hot  <= i_cfg_data;
                default:  ;
            endcase
        end
    end

    // Transaction control and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= T_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                T_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= T_EMA;
                    end
                end
                T_EMA: begin
                    if (ema_stat.done) begin
                        r_dbm   <= level_dbm;
                        r_state <= T_HEAT;
                    end
                end
                T_HEAT: begin
                    if (heat_stat.done && out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_dbm   <= r_dbm;
                        r_out_heat  <= heat;
                        r_state     <= T_IDLE;
                    end
                end
                default: r_state <= T_IDLE;
            endcase
        end
    end

    rshc_ema u_ema (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (ema_ctl),
        .i_sample (i_rssi_sample),
        .o_stat   (ema_stat),
        .o_level  (level)
    );

    rshc_heat u_heat (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (heat_ctl),
        .i_dbm   (level_dbm),
        .i_cold  (r_cold),
        .i_hot   (r_hot),
        .o_stat  (heat_stat),
        .o_heat  (heat)
    );

    assign o_out_valid    = r_out_valid;
    assign o_smoothed_dbm = r_out_dbm;
    assign o_heat_red     = r_out_heat;
    assign o_heat_blue    = HEAT_MAX - r_out_heat;

endmodule

FILE: src/rshc_checker.sv
// ----------------------------------------------------------------------------
// rshc_checker: port-level checks for the RSSI smoother
// Watches the top-level ports over time and is bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rshc_checker
    import rshc_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_in_valid,
    input logic                   o_in_ready,
    input logic                   o_out_valid,
    input logic                   i_out_ready,
    input logic signed [DbmW-1:0] o_smoothed_dbm,
    input logic [HeatW-1:0]       o_heat_red,
    input logic [HeatW-1:0]       o_heat_blue
);

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its payload.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_heat_red) && $stable(o_smoothed_dbm))
        else $error("result payload changed while stalled");

    // Red and blue always add up to full scale.
    a_colour_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (9'(o_heat_red) + 9'(o_heat_blue)) == 9'(HEAT_MAX))
        else $error("red and blue do not sum to full scale");

    // One sample at a time: no new transaction right after one is taken.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input taken while a sample is in work");

    // A new result is loaded only while a sample is in work.
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(!o_in_ready))
        else $error("result appeared with no sample in work");

endmodule

bind rssi_smoother_heat_colour_top rshc_checker u_rshc_checker (.*);
